// ----- hdl/pulse_period_duty_meter_core_defines.svh -----
// assertion macros shared by the pulse period and duty meter rtl
`ifndef PULSE_PERIOD_DUTY_METER_CORE_DEFINES_SVH
`define PULSE_PERIOD_DUTY_METER_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define PPDM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define PPDM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/ppdm_pkg.sv -----
// types and constants of the pulse period and duty meter
package ppdm_pkg;

  // capture timestamp width
  localparam int TIMER_BITS = 16;
  // divider operand widths
  localparam int QUO_W      = 27;
  localparam int DEN_W      = TIMER_BITS;
  localparam int CNT_W      = $clog2(QUO_W);
  // result field widths
  localparam int DUTY_W     = 7;
  localparam int RATE_W     = 27;
  // config port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(1000000);
  localparam logic [0:0] REG_TICK_RATE = 1'b0;
  localparam logic [QUO_W-1:0] PCT_SCALE = QUO_W'(100);

  // edge sequence position
  typedef enum logic [1:0] {
    PH_RISE1 = 2'd0,
    PH_FALL  = 2'd1,
    PH_RISE2 = 2'd2
  } phase_t;

  // sequencer states
  typedef enum logic [5:0] {
    S_IDLE       = 6'b000001,
    S_DUTY_START = 6'b000010,
    S_DUTY_WAIT  = 6'b000100,
    S_FREQ_START = 6'b001000,
    S_FREQ_WAIT  = 6'b010000,
    S_PUSH       = 6'b100000
  } state_t;

  // divider request and response
  typedef struct packed {
    logic             start;
    logic [QUO_W-1:0] dividend;
    logic [DEN_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [QUO_W-1:0] quotient;
  } div_rsp_t;

endpackage

// ----- hdl/ppdm_divider.sv -----
// shared restoring divider, one quotient bit per cycle
module ppdm_divider
  import ppdm_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DEN_W-1:0] dvs_r, dvs_nxt;
  logic [QUO_W-1:0] quo_r, quo_nxt;
  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   rem_sub;
  logic             fits;

  // trial subtract of the shifted partial remainder
  assign rem_sh  = {rem_r, quo_r[QUO_W-1]};
  assign rem_sub = rem_sh - {1'b0, dvs_r};
  assign fits    = rem_sh >= {1'b0, dvs_r};

  // step control
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    quo_nxt  = quo_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      dvs_nxt  = req.divisor;
      quo_nxt  = req.dividend;
    end else if (busy_r) begin
      rem_nxt = fits ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      quo_nxt = {quo_r[QUO_W-2:0], fits};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(QUO_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    quo_r <= quo_nxt;
  end

  assign rsp.busy     = busy_r;
  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

// ----- hdl/pulse_period_duty_meter_core.sv -----
// top level of the pulse period and duty meter
//
// channel  direction  handshake                 payload
// in_      request    in_tvalid / in_tready     tdata: capture_time; tuser: edge_rising
// out_     result     out_tvalid / out_tready   tdata: valid_res, high, period, duty, freq
// cfg_     register   apb, pready always high   tick_rate_hz at byte address 0
//
// an edge that does not finish a rise/fall/rise sequence is accepted in idle and produces no result
// a completing edge runs two 27-step passes of the shared divider, duty first and then frequency
// a completing edge with non-increasing timestamps skips the divider and goes straight to the push
// rst_n is synchronous; it clears the edge sequence and loads tick rate 1000000
// a result waits in the output register; a stalled output holds back the next one
module pulse_period_duty_meter_core
  import ppdm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // capture requests
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [15:0]           in_tdata,   // [15:0] capture_time
  input  logic                  in_tuser,   // [0] edge_rising
  // results
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [71:0]           out_tdata,  // [0] valid_res, [16:1] high_ticks,
                                            // [32:17] period_ticks, [39:33] duty_percent,
                                            // [66:40] frequency_hz, [71:67] zero
  // register port
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

`include "pulse_period_duty_meter_core_defines.svh"

  state_t                state_r, state_nxt;
  phase_t                phase_r, phase_nxt;
  logic [RATE_W-1:0]     rate_r;
  logic [TIMER_BITS-1:0] rise_r, rise_nxt;
  logic [TIMER_BITS-1:0] fall_r, fall_nxt;
  logic                  res_ok_r, res_ok_nxt;
  logic [TIMER_BITS-1:0] high_r, high_nxt;
  logic [TIMER_BITS-1:0] period_r, period_nxt;
  logic [DUTY_W-1:0]     duty_r, duty_nxt;
  logic [RATE_W-1:0]     freq_r, freq_nxt;
  logic                  ov_r, ov_nxt;
  logic [71:0]           od_r, od_nxt;
  logic                  in_acc;
  logic                  cfg_wr;
  logic [TIMER_BITS-1:0] cap_t;
  logic                  seq_ok;
  logic                  out_free;
  div_req_t              div_req;
  div_rsp_t              div_rsp;

  assign cap_t     = in_tdata[TIMER_BITS-1:0];
  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign seq_ok    = (rise_r < fall_r) && (fall_r < cap_t);
  assign out_free  = !ov_r || out_tready;

  // register port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
                      && (cfg_paddr[2] == REG_TICK_RATE);
  assign cfg_prdata = (cfg_paddr[2] == REG_TICK_RATE)
                      ? CFG_DATA_W'(rate_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r <= RATE_RESET;
    end else if (cfg_wr) begin
      rate_r <= cfg_pwdata[RATE_W-1:0];
    end
  end

  // shared divider requests
  always_comb begin
    div_req.start    = (state_r == S_DUTY_START) || (state_r == S_FREQ_START);
    div_req.divisor  = period_r;
    div_req.dividend = (state_r == S_DUTY_START)
                       ? QUO_W'({{(QUO_W-TIMER_BITS){1'b0}}, high_r} * PCT_SCALE)
                       : rate_r;
  end

  ppdm_divider u_div (
    .clk (clk),
    .rst_n (rst_n),
    .req (div_req),
    .rsp (div_rsp)
  );

  // sequencer and edge tracking
  always_comb begin
    state_nxt  = state_r;
    phase_nxt  = phase_r;
    rise_nxt   = rise_r;
    fall_nxt   = fall_r;
    res_ok_nxt = res_ok_r;
    high_nxt   = high_r;
    period_nxt = period_r;
    duty_nxt   = duty_r;
    freq_nxt   = freq_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (phase_r)
            PH_FALL: begin
              if (!in_tuser) begin
                fall_nxt  = cap_t;
                phase_nxt = PH_RISE2;
              end
            end
            PH_RISE2: begin
              if (in_tuser) begin
                phase_nxt  = PH_RISE1;
                res_ok_nxt = seq_ok;
                duty_nxt   = '0;
                freq_nxt   = '0;
                if (seq_ok) begin
                  high_nxt   = fall_r - rise_r;
                  period_nxt = cap_t - rise_r;
                  state_nxt  = S_DUTY_START;
                end else begin
                  high_nxt   = '0;
                  period_nxt = '0;
                  state_nxt  = S_PUSH;
                end
              end
            end
            default: begin
              if (in_tuser) begin
                rise_nxt  = cap_t;
                phase_nxt = PH_FALL;
              end
            end
          endcase
        end
      end
      S_DUTY_START: state_nxt = S_DUTY_WAIT;
      S_DUTY_WAIT: begin
        if (div_rsp.done) begin
          duty_nxt  = div_rsp.quotient[DUTY_W-1:0];
          state_nxt = S_FREQ_START;
        end
      end
      S_FREQ_START: state_nxt = S_FREQ_WAIT;
      S_FREQ_WAIT: begin
        if (div_rsp.done) begin
          freq_nxt  = div_rsp.quotient[RATE_W-1:0];
          state_nxt = S_PUSH;
        end
      end
      S_PUSH: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // output register
  always_comb begin
    ov_nxt = ov_r;
    od_nxt = od_r;
    if (ov_r && out_tready) begin
      ov_nxt = 1'b0;
    end
    if ((state_r == S_PUSH) && out_free) begin
      ov_nxt = 1'b1;
      od_nxt = {5'b0, freq_r, duty_r, period_r, high_r, res_ok_r};
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      phase_r <= PH_RISE1;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      ov_r    <= ov_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    rise_r   <= rise_nxt;
    fall_r   <= fall_nxt;
    res_ok_r <= res_ok_nxt;
    high_r   <= high_nxt;
    period_r <= period_nxt;
    duty_r   <= duty_nxt;
    freq_r   <= freq_nxt;
    od_r     <= od_nxt;
  end

  // checks
  `PPDM_ASSERT_IMP(a_div_start_idle, div_req.start, !div_rsp.busy,
    "divider restarted while busy")
  `PPDM_ASSERT_IMP(a_div_done_waited, div_rsp.done,
    (state_r == S_DUTY_WAIT) || (state_r == S_FREQ_WAIT),
    "divider finished outside a wait state")
  `PPDM_ASSERT_IMP(a_bad_res_zero, ov_r && !od_r[0], od_r[71:1] == '0,
    "rejected result carries nonzero fields")
  `PPDM_ASSERT_IMP(a_duty_range, ov_r, od_r[39:33] < DUTY_W'(100),
    "duty above 99 percent")

endmodule
